// ===== hw/rtl/tac_pkg.sv =====
package tac_pkg;

  localparam int MAX_ADC_BITS   = 16;
  localparam int MIN_ADC_BITS   = 10;
  localparam int LN_TABLE_DEPTH = 256;
  localparam int LN_ABITS       = $clog2(LN_TABLE_DEPTH);

  localparam int CODE_W = 16;
  localparam int BITS_W = 5;
  localparam int TEMP_W = 16;

  localparam logic [BITS_W-1:0] ADC_BITS_RST = BITS_W'(12);

  localparam int RREF  = 10000;
  localparam int RES_W = $clog2(RREF) + MAX_ADC_BITS;
  localparam int E_W   = $clog2(RES_W);

  // mantissa fraction and table interpolation
  localparam int FRAC_W = 30;
  localparam int FR_W   = FRAC_W - LN_ABITS;
  localparam int ROM_W  = 32;
  localparam int LN_W   = 32 + E_W;
  localparam int LNQ_W  = LN_W - 8;

  localparam logic [ROM_W-1:0] LN2_Q32 = 32'd2977044472;

  localparam logic [63:0] SH_A_Q40 =
    ((64'd1129148 << 40) + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] SH_B_Q40 =
    ((64'd234125 << 40) + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] SH_C_Q44 =
    ((64'd876741 << 44) + 64'd5000000000000) / 64'd10000000000000;

  localparam int B_W   = 28;
  localparam int C_W   = 21;
  localparam int L2_W  = 2 * LNQ_W - 24;
  localparam int L3_W  = L2_W + LNQ_W - 24;
  localparam int BT_W  = B_W + LNQ_W - 24;
  localparam int CT_W  = C_W + L3_W - 28;
  localparam int S_W   = 35;
  localparam int N2_W  = 47;
  localparam int K_W   = 17;

  localparam logic [N2_W-1:0] NUM_CK = N2_W'(100) << 40;

  localparam int ZERO_C_CENTI = 27315;
  localparam int TEMP_MAX     = 30000;

  localparam int RES_LAT  = RES_W + 2;
  localparam int LN_LAT   = 5;
  localparam int POLY_LAT = 4;
  localparam int PIPE_LAT = RES_LAT + LN_LAT + POLY_LAT + K_W + 2;

  typedef struct packed {
    logic vld;
    logic inv;
  } tag_t;

  // elaboration-time shift-subtract divide for the table build
  function automatic logic [63:0] cdiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1 + i/depth) in Q32, atanh series
  function automatic logic [ROM_W-1:0] ln_rom(int i);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] sum;
    z   = cdiv(64'(i) << 32, 64'(2 * LN_TABLE_DEPTH + i));
    z2  = (z * z) >> 32;
    t   = z;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (t != '0) begin
        sum = sum + cdiv(t, 64'(2 * k + 1));
        t   = (t * z2) >> 32;
      end
    end
    return ROM_W'(sum << 1);
  endfunction

endpackage

// ===== hw/rtl/tac_res.sv =====
module tac_res (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [tac_pkg::CODE_W-1:0]   code,
  input  logic [tac_pkg::BITS_W-1:0]   adc_bits,
  output tac_pkg::tag_t                res_tag,
  output logic [tac_pkg::RES_W-1:0]    res_val
);

  localparam int NST = tac_pkg::RES_W;
  localparam int CW  = tac_pkg::CODE_W;

  logic [tac_pkg::BITS_W-1:0] bits_c;

  tac_pkg::tag_t            tag_r   [NST+1];
  tac_pkg::tag_t            tag_nxt [NST+1];
  logic [CW-1:0]            rem_r   [NST+1];
  logic [CW-1:0]            rem_nxt [NST+1];
  logic [CW-1:0]            den_r   [NST+1];
  logic [CW-1:0]            den_nxt [NST+1];
  logic [NST-1:0]           num_r   [NST+1];
  logic [NST-1:0]           num_nxt [NST+1];
  logic [NST-1:0]           quo_r   [NST+1];
  logic [NST-1:0]           quo_nxt [NST+1];
  logic [CW:0]              trial   [NST];
  logic                     ge      [NST];

  tac_pkg::tag_t            otag_r;
  tac_pkg::tag_t            otag_nxt;
  logic [NST-1:0]           oval_r;
  logic [NST-1:0]           oval_nxt;

  always_comb begin
    bits_c = adc_bits;
    if (adc_bits < tac_pkg::BITS_W'(tac_pkg::MIN_ADC_BITS)) begin
      bits_c = tac_pkg::BITS_W'(tac_pkg::MIN_ADC_BITS);
    end else if (adc_bits > tac_pkg::BITS_W'(tac_pkg::MAX_ADC_BITS)) begin
      bits_c = tac_pkg::BITS_W'(tac_pkg::MAX_ADC_BITS);
    end
    tag_nxt[0] = '{vld: in_vld, inv: (code == '0)};
    num_nxt[0] = NST'(tac_pkg::RREF) << bits_c;
    den_nxt[0] = code;
    rem_nxt[0] = '0;
    quo_nxt[0] = '0;
    // one quotient bit per stage, msb first
    for (int j = 0; j < NST; j++) begin
      trial[j]     = {rem_r[j], num_r[j][NST-1-j]};
      ge[j]        = (trial[j] >= {1'b0, den_r[j]});
      rem_nxt[j+1] = ge[j] ? CW'(trial[j] - {1'b0, den_r[j]}) : CW'(trial[j]);
      quo_nxt[j+1] = {quo_r[j][NST-2:0], ge[j]};
      num_nxt[j+1] = num_r[j];
      den_nxt[j+1] = den_r[j];
      tag_nxt[j+1] = tag_r[j];
    end
    otag_nxt.vld = tag_r[NST].vld;
    otag_nxt.inv = tag_r[NST].inv || (quo_r[NST] <= NST'(tac_pkg::RREF));
    oval_nxt     = quo_r[NST] - NST'(tac_pkg::RREF);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= NST; j++) begin
      rem_r[j] <= rem_nxt[j];
      den_r[j] <= den_nxt[j];
      num_r[j] <= num_nxt[j];
      quo_r[j] <= quo_nxt[j];
      tag_r[j] <= rst_n ? tag_nxt[j] : '0;
    end
    otag_r <= rst_n ? otag_nxt : '0;
    oval_r <= oval_nxt;
  end

  assign res_tag = otag_r;
  assign res_val = oval_r;

endmodule

// ===== hw/rtl/tac_ln.sv =====
module tac_ln (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tac_pkg::tag_t               in_tag,
  input  logic [tac_pkg::RES_W-1:0]   r_val,
  output tac_pkg::tag_t               ln_tag,
  output logic [tac_pkg::LNQ_W-1:0]   lq
);

  localparam int RW = tac_pkg::RES_W;
  localparam int EW = tac_pkg::E_W;
  localparam int AB = tac_pkg::LN_ABITS;
  localparam int FW = tac_pkg::FR_W;
  localparam int MW = tac_pkg::ROM_W;
  localparam int LW = tac_pkg::LN_W;

  logic [MW-1:0] rom [tac_pkg::LN_TABLE_DEPTH+1];

  for (genvar g = 0; g <= tac_pkg::LN_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [MW-1:0] ROM_V = tac_pkg::ln_rom(g);
    assign rom[g] = ROM_V;
  end

  tac_pkg::tag_t t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt, t5_r, t5_nxt;
  logic [RW-1:0]  r1_r, r1_nxt;
  logic [EW-1:0]  e1_r, e1_nxt, e2_r, e2_nxt;
  logic [RW-1:0]  norm;
  logic [tac_pkg::FRAC_W-1:0] frac;
  logic [AB-1:0]  idx2_r, idx2_nxt;
  logic [FW-1:0]  fr2_r, fr2_nxt, fr3_r, fr3_nxt;
  logic [AB:0]    idx_hi;
  logic [MW-1:0]  lo3_r, lo3_nxt, diff3_r, diff3_nxt, interp4_r, interp4_nxt;
  logic [LW-1:0]  elog3_r, elog3_nxt, base4_r, base4_nxt, ln_sum;
  logic [MW+FW-1:0] prod;
  logic [tac_pkg::LNQ_W-1:0] lq5_r, lq5_nxt;

  always_comb begin
    // leading one position
    e1_nxt = '0;
    for (int i = 0; i < RW; i++) begin
      if (r_val[i]) begin
        e1_nxt = EW'(i);
      end
    end
    r1_nxt = r_val;
    t1_nxt = in_tag;

    norm     = r1_r << (EW'(RW - 1) - e1_r);
    frac     = tac_pkg::FRAC_W'(norm[RW-2:0]) << (tac_pkg::FRAC_W - RW + 1);
    idx2_nxt = frac[tac_pkg::FRAC_W-1:FW];
    fr2_nxt  = frac[FW-1:0];
    e2_nxt   = e1_r;
    t2_nxt   = t1_r;

    idx_hi    = {1'b0, idx2_r} + (AB+1)'(1);
    lo3_nxt   = rom[{1'b0, idx2_r}];
    diff3_nxt = rom[idx_hi] - rom[{1'b0, idx2_r}];
    elog3_nxt = LW'(e2_r) * LW'(tac_pkg::LN2_Q32);
    fr3_nxt   = fr2_r;
    t3_nxt    = t2_r;

    prod        = (MW+FW)'(diff3_r) * (MW+FW)'(fr3_r);
    interp4_nxt = MW'(prod >> FW);
    base4_nxt   = elog3_r + LW'(lo3_r);
    t4_nxt      = t3_r;

    ln_sum  = base4_r + LW'(interp4_r);
    lq5_nxt = tac_pkg::LNQ_W'(ln_sum >> 8);
    t5_nxt  = t4_r;
  end

  always_ff @(posedge clk) begin
    r1_r      <= r1_nxt;
    e1_r      <= e1_nxt;
    idx2_r    <= idx2_nxt;
    fr2_r     <= fr2_nxt;
    e2_r      <= e2_nxt;
    lo3_r     <= lo3_nxt;
    diff3_r   <= diff3_nxt;
    elog3_r   <= elog3_nxt;
    fr3_r     <= fr3_nxt;
    interp4_r <= interp4_nxt;
    base4_r   <= base4_nxt;
    lq5_r     <= lq5_nxt;
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
      t5_r <= '0;
    end else begin
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
      t4_r <= t4_nxt;
      t5_r <= t5_nxt;
    end
  end

  assign ln_tag = t5_r;
  assign lq     = lq5_r;

endmodule

// ===== hw/rtl/thermistor_adc_to_celsius.sv =====
// channel   ports                                  transfer
// input     start, busy, in_adc_code              start high and busy low
// config    cfg_we, cfg_wdata                     cfg_we high
// result    out_valid, out_temp_centi_c,          out_valid high, one cycle
//           out_invalid
// fully pipelined, one sample per cycle, busy stays low
// each accepted input passes, in order, through the resistance
// divider (one quotient bit per stage), the log unit, the
// polynomial, and the reciprocal divider and output register
// synchronous reset clears valid bits and sets adc_bits to 12
// the receiver cannot stall, so nothing ever holds
module thermistor_adc_to_celsius (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tac_pkg::CODE_W-1:0]         in_adc_code,
  input  logic                               cfg_we,
  input  logic [tac_pkg::BITS_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  output logic signed [tac_pkg::TEMP_W-1:0]  out_temp_centi_c,
  output logic                               out_invalid
);

  localparam int LQW = tac_pkg::LNQ_W;
  localparam int SW  = tac_pkg::S_W;
  localparam int KW  = tac_pkg::K_W;
  localparam int NW  = tac_pkg::N2_W;

  logic [tac_pkg::BITS_W-1:0] adc_bits_r, adc_bits_nxt;

  tac_pkg::tag_t              res_tag, ln_tag;
  logic [tac_pkg::RES_W-1:0]  res_val;
  logic [LQW-1:0]             lq;

  tac_res u_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .code     (in_adc_code),
    .adc_bits (adc_bits_r),
    .res_tag  (res_tag),
    .res_val  (res_val)
  );

  tac_ln u_ln (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_tag (res_tag),
    .r_val  (res_val),
    .ln_tag (ln_tag),
    .lq     (lq)
  );

  tac_pkg::tag_t p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt, p4_r, p4_nxt;
  logic [2*LQW-1:0]                   sq;
  logic [tac_pkg::B_W+LQW-1:0]        bprod;
  logic [tac_pkg::L2_W+LQW-1:0]       cube;
  logic [tac_pkg::C_W+tac_pkg::L3_W-1:0] cprod;
  logic [LQW-1:0]                     lq1_r, lq1_nxt;
  logic [tac_pkg::L2_W-1:0]           l2_r, l2_nxt;
  logic [tac_pkg::BT_W-1:0]           bt1_r, bt1_nxt, bt2_r, bt2_nxt, bt3_r, bt3_nxt;
  logic [tac_pkg::L3_W-1:0]           l3_r, l3_nxt;
  logic [tac_pkg::CT_W-1:0]           ct_r, ct_nxt;
  logic [SW-1:0]                      s4_r, s4_nxt;
  logic [NW-1:0]                      n2;

  tac_pkg::tag_t dtag_r   [KW+1];
  tac_pkg::tag_t dtag_nxt [KW+1];
  logic [SW-1:0] drem_r   [KW+1];
  logic [SW-1:0] drem_nxt [KW+1];
  logic [SW-1:0] dden_r   [KW+1];
  logic [SW-1:0] dden_nxt [KW+1];
  logic [KW-1:0] dlow_r   [KW+1];
  logic [KW-1:0] dlow_nxt [KW+1];
  logic [KW-1:0] dquo_r   [KW+1];
  logic [KW-1:0] dquo_nxt [KW+1];
  logic [SW:0]   trial    [KW];
  logic          ge       [KW];

  logic [KW:0]                       kdiff;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_inv_r, out_inv_nxt;
  logic signed [tac_pkg::TEMP_W-1:0] out_temp_r, out_temp_nxt;

  always_comb begin
    adc_bits_nxt = cfg_we ? cfg_wdata : adc_bits_r;

    // squared and linear terms
    sq      = (2*LQW)'(lq) * (2*LQW)'(lq);
    l2_nxt  = tac_pkg::L2_W'(sq >> 24);
    bprod   = (tac_pkg::B_W+LQW)'(tac_pkg::SH_B_Q40) * (tac_pkg::B_W+LQW)'(lq);
    bt1_nxt = tac_pkg::BT_W'(bprod >> 24);
    lq1_nxt = lq;
    p1_nxt  = ln_tag;

    cube    = (tac_pkg::L2_W+LQW)'(l2_r) * (tac_pkg::L2_W+LQW)'(lq1_r);
    l3_nxt  = tac_pkg::L3_W'(cube >> 24);
    bt2_nxt = bt1_r;
    p2_nxt  = p1_r;

    cprod   = (tac_pkg::C_W+tac_pkg::L3_W)'(tac_pkg::SH_C_Q44)
              * (tac_pkg::C_W+tac_pkg::L3_W)'(l3_r);
    ct_nxt  = tac_pkg::CT_W'(cprod >> 28);
    bt3_nxt = bt2_r;
    p3_nxt  = p2_r;

    s4_nxt  = SW'(tac_pkg::SH_A_Q40) + SW'(bt3_r) + SW'(ct_r);
    p4_nxt  = p3_r;

    // rounded reciprocal, quotient known to fit KW bits
    n2          = tac_pkg::NUM_CK + NW'(s4_r >> 1);
    drem_nxt[0] = SW'(n2 >> KW);
    dlow_nxt[0] = n2[KW-1:0];
    dden_nxt[0] = s4_r;
    dquo_nxt[0] = '0;
    dtag_nxt[0] = p4_r;
    for (int j = 0; j < KW; j++) begin
      trial[j]      = {drem_r[j], dlow_r[j][KW-1-j]};
      ge[j]         = (trial[j] >= {1'b0, dden_r[j]});
      drem_nxt[j+1] = ge[j] ? SW'(trial[j] - {1'b0, dden_r[j]}) : SW'(trial[j]);
      dquo_nxt[j+1] = {dquo_r[j][KW-2:0], ge[j]};
      dlow_nxt[j+1] = dlow_r[j];
      dden_nxt[j+1] = dden_r[j];
      dtag_nxt[j+1] = dtag_r[j];
    end

    kdiff         = (KW+1)'(dquo_r[KW]) - (KW+1)'(tac_pkg::ZERO_C_CENTI);
    out_valid_nxt = dtag_r[KW].vld;
    out_inv_nxt   = dtag_r[KW].inv;
    if (dtag_r[KW].inv) begin
      out_temp_nxt = '0;
    end else if (dquo_r[KW] > KW'(tac_pkg::TEMP_MAX + tac_pkg::ZERO_C_CENTI)) begin
      out_temp_nxt = tac_pkg::TEMP_W'(tac_pkg::TEMP_MAX);
    end else begin
      out_temp_nxt = tac_pkg::TEMP_W'(kdiff);
    end
  end

  always_ff @(posedge clk) begin
    lq1_r <= lq1_nxt;
    l2_r  <= l2_nxt;
    bt1_r <= bt1_nxt;
    l3_r  <= l3_nxt;
    bt2_r <= bt2_nxt;
    ct_r  <= ct_nxt;
    bt3_r <= bt3_nxt;
    s4_r  <= s4_nxt;
    for (int j = 0; j <= KW; j++) begin
      drem_r[j] <= drem_nxt[j];
      dlow_r[j] <= dlow_nxt[j];
      dden_r[j] <= dden_nxt[j];
      dquo_r[j] <= dquo_nxt[j];
      dtag_r[j] <= rst_n ? dtag_nxt[j] : '0;
    end
    out_temp_r <= out_temp_nxt;
    out_inv_r  <= out_inv_nxt;
    if (!rst_n) begin
      adc_bits_r  <= tac_pkg::ADC_BITS_RST;
      p1_r        <= '0;
      p2_r        <= '0;
      p3_r        <= '0;
      p4_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      adc_bits_r  <= adc_bits_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      p3_r        <= p3_nxt;
      p4_r        <= p4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy             = 1'b0;
  assign out_valid        = out_valid_r;
  assign out_temp_centi_c = out_temp_r;
  assign out_invalid      = out_inv_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(tac_pkg::PIPE_LAT) out_valid)
    else $error("transfer did not reach the result port on time");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_temp_centi_c == '0))
    else $error("invalid result carries a temperature");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invalid) |->
      (out_temp_centi_c <= 16'sd30000 && out_temp_centi_c >= -16'sd27315))
    else $error("temperature out of range");

  a_sum_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (p4_r.vld && !p4_r.inv) |-> (s4_r >= SW'(tac_pkg::SH_A_Q40)))
    else $error("denominator below constant term");

endmodule

// ===== tb/sv/thermistor_adc_to_celsius_tb.sv =====
module thermistor_adc_to_celsius_tb;

  localparam int LATENCY = 60;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [tac_pkg::TEMP_W-1:0] temp;
    logic                              inv;
  } reading_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [tac_pkg::CODE_W-1:0]        in_adc_code;
  logic                              cfg_we;
  logic [tac_pkg::BITS_W-1:0]        cfg_wdata;
  logic                              out_valid;
  logic signed [tac_pkg::TEMP_W-1:0] out_temp_centi_c;
  logic                              out_invalid;

  reading_t                   pending_readings[$];
  logic [tac_pkg::BITS_W-1:0] res_bits;
  logic [63:0]                log_table[0:tac_pkg::LN_TABLE_DEPTH];
  int                         fail_count;
  longint                     cycle_count;

  thermistor_adc_to_celsius i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_adc_code      (in_adc_code),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_temp_centi_c (out_temp_centi_c),
    .out_invalid      (out_invalid)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ln(1 + i/depth) in q32 by the atanh series
  function automatic logic [63:0] table_entry(int i);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] acc;
    z   = (64'(i) << 32) / 64'(2 * tac_pkg::LN_TABLE_DEPTH + i);
    z2  = (z * z) >> 32;
    t   = z;
    acc = '0;
    for (int k = 0; k < 64; k++) begin
      if (t != 0) begin
        acc = acc + t / 64'(2 * k + 1);
        t   = (t * z2) >> 32;
      end
    end
    return acc << 1;
  endfunction

  function automatic logic [63:0] natural_log_q32(logic [63:0] r);
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] hi;
    e = 0;
    while (e < 63 && (r >> (e + 1)) != 0) e++;
    if (e <= 30) f = r << (30 - e);
    else f = r >> (e - 30);
    f   = f - (64'd1 << 30);
    p   = f * tac_pkg::LN_TABLE_DEPTH;
    idx = p >> 30;
    rem = p & ((64'd1 << 30) - 1);
    lo  = log_table[idx];
    hi  = log_table[idx + 1];
    return e * 64'(tac_pkg::LN2_Q32) + lo + (((hi - lo) * rem) >> 30);
  endfunction

  function automatic reading_t code_to_celsius(logic [tac_pkg::CODE_W-1:0] code);
    reading_t    res;
    int          nbits;
    logic [63:0] q;
    logic [63:0] lq;
    logic [63:0] l2;
    logic [63:0] l3;
    logic [63:0] s;
    logic [63:0] kel;
    longint      t;
    nbits = res_bits;
    if (nbits < tac_pkg::MIN_ADC_BITS) nbits = tac_pkg::MIN_ADC_BITS;
    if (nbits > tac_pkg::MAX_ADC_BITS) nbits = tac_pkg::MAX_ADC_BITS;
    res.temp = '0;
    res.inv  = 1'b1;
    if (code == 0) return res;
    q = (64'(tac_pkg::RREF) << nbits) / 64'(code);
    if (q <= tac_pkg::RREF) return res;
    lq  = natural_log_q32(q - tac_pkg::RREF) >> 8;
    l2  = (lq * lq) >> 24;
    l3  = (l2 * lq) >> 24;
    s   = tac_pkg::SH_A_Q40 + ((tac_pkg::SH_B_Q40 * lq) >> 24)
          + ((tac_pkg::SH_C_Q44 * l3) >> 28);
    kel = ((64'd100 << 40) + s / 2) / s;
    t   = longint'(kel) - tac_pkg::ZERO_C_CENTI;
    if (t > tac_pkg::TEMP_MAX) t = tac_pkg::TEMP_MAX;
    if (t < -tac_pkg::ZERO_C_CENTI) t = -tac_pkg::ZERO_C_CENTI;
    res.temp = tac_pkg::TEMP_W'(t);
    res.inv  = 1'b0;
    return res;
  endfunction

  function automatic int gap_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_code(logic [tac_pkg::CODE_W-1:0] code, bit gaps);
    int g;
    g = gaps ? gap_length() : 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
    start       <= 1'b1;
    in_adc_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_readings.push_back(code_to_celsius(code));
    @(negedge clk);
  endtask

  task automatic write_bits(logic [tac_pkg::BITS_W-1:0] value);
    start <= 1'b0;
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    res_bits  = value;
  endtask

  function automatic logic [tac_pkg::CODE_W-1:0] random_code();
    int nbits;
    int sel;
    nbits = res_bits < tac_pkg::MIN_ADC_BITS ? tac_pkg::MIN_ADC_BITS :
            res_bits > tac_pkg::MAX_ADC_BITS ? tac_pkg::MAX_ADC_BITS : res_bits;
    sel = $urandom_range(0, 9);
    if (sel == 0) return tac_pkg::CODE_W'($urandom());
    if (sel == 1) return tac_pkg::CODE_W'((1 << nbits) - $urandom_range(0, 4));
    if (sel == 2) return tac_pkg::CODE_W'($urandom_range(0, 4));
    return tac_pkg::CODE_W'($urandom_range(1, (1 << nbits) - 1));
  endfunction

  task automatic test_directed();
    logic [tac_pkg::CODE_W-1:0] codes[$];
    codes = '{16'd0, 16'd1, 16'd2, 16'd4095, 16'd4096, 16'd4097, 16'd2048,
              16'd2047, 16'd2049, 16'd1000, 16'd3000, 16'd65535, 16'hAAAA,
              16'h5555, 16'd100, 16'd3900, 16'd10};
    foreach (codes[i]) send_code(codes[i], 1'b0);
  endtask

  task automatic test_resolution_sweep();
    logic [tac_pkg::BITS_W-1:0] settings[$];
    settings = '{5'd0, 5'd9, 5'd10, 5'd16, 5'd31, 5'd17, 5'd14};
    foreach (settings[i]) begin
      write_bits(settings[i]);
      send_code(16'd1, 1'b0);
      send_code(16'd65535, 1'b0);
      send_code(16'd512, 1'b0);
      for (int n = 0; n < 20; n++) send_code(random_code(), 1'b1);
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_bits(tac_pkg::BITS_W'($urandom_range(10, 16)));
      for (int n = 0; n < 110; n++) send_code(random_code(), ph != 2);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result temp %0d invalid %0b", $time,
                 out_temp_centi_c, out_invalid);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_temp_centi_c !== want.temp) begin
          $display("%0t: temp expected %0d actual %0d", $time, want.temp,
                   out_temp_centi_c);
          fail_count++;
        end
        if (out_invalid !== want.inv) begin
          $display("%0t: invalid expected %0b actual %0b", $time, want.inv,
                   out_invalid);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("thermistor_adc_to_celsius test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= tac_pkg::LN_TABLE_DEPTH; i++) log_table[i] = table_entry(i);
    fail_count  = 0;
    cycle_count = 0;
    res_bits    = tac_pkg::ADC_BITS_RST;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_adc_code = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_resolution_sweep();
    test_random();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("thermistor_adc_to_celsius test passed");
    end else begin
      $display("thermistor_adc_to_celsius test failed");
    end
    $finish;
  end

endmodule
